FILE: hw/rtl/gtrsp_pkg.sv
// Shared types and constants for the greedy two-resource server packer.
// No dependencies; imported by greedy_two_resource_server_packing.
`timescale 1ns / 1ps
`default_nettype none

package gtrsp_pkg;

    localparam int CPU_W       = 8;
    localparam int MEM_W       = 10;
    localparam int MAX_RESULTS = 16;
    localparam int DIV_STEPS   = 10;

    localparam logic [7:0] SERVER_CPU_RST = 8'd56;
    localparam logic [9:0] SERVER_MEM_RST = 10'd128;
    localparam logic [4:0] TYPE_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PACK  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_ACK     = 2'd1,
        ST_NOTHING = 2'd2,
        ST_TOO_BIG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_SERVER_CPU   = 2'd0,
        CFG_SERVER_MEM   = 2'd1,
        CFG_OPTIMIZE_MEM = 2'd2,
        CFG_TYPE_COUNT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_NONE,
        S_BIG,
        S_SEL,
        S_DIV,
        S_MIN,
        S_MUL,
        S_UPD,
        S_REP,
        S_REP_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  type_index;
        logic [7:0]  type_cpu;
        logic [9:0]  type_mem;
        logic [15:0] type_demand;
    } t_in;

    typedef struct packed {
        logic [15:0] server_number;
        logic [3:0]  placed_type;
        logic [15:0] placed_count;
        logic [1:0]  status;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

FILE: hw/rtl/greedy_two_resource_server_packing.sv
// Greedy two-resource server packer: type table memory, scan sequencer and divider.
// Depends on gtrsp_pkg.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_stall), results leave
// on the output channel (o_out_valid / i_out_stall) through one output register, and
// the four settings are to be written on the cfg channel (always ready) only while
// idle, which the block itself does not enforce. A load or clear gives one ack beat.
// A pack first scans the n active table entries for the empty and oversized cases,
// then runs selection rounds: each round reads every active entry from the table
// memory, then a 10-step restoring divider, a min, a multiply and a write-back.
// Placement beats leave in ascending type order, the final one flagged last. One
// command is worked on at a time; a stalled receiver holds the output register
// and the sequencer waits for it.
// Reset restores the settings, empties the table (all demands zero) and sets the
// server number to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module greedy_two_resource_server_packing #(
    parameter int MAX_TYPES  = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire gtrsp_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output gtrsp_pkg::t_out      o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [9:0]      i_cfg_data
);
    import gtrsp_pkg::*;

    localparam int IDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int CNT_W = $clog2(MAX_TYPES + 1);

    typedef struct packed {
        logic [CPU_W-1:0]      cpu;
        logic [MEM_W-1:0]      mem;
        logic [COUNT_BITS-1:0] rem;
    } t_entry;

    function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
        sat16 = (32'(v) > 32'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    // settings
    logic [7:0] r_server_cpu;
    logic [9:0] r_server_mem;
    logic       r_optimize_mem;
    logic [4:0] r_type_count;

    t_state r_state, n_state;

    // memories
    t_entry                r_tab_mem [MAX_TYPES];
    t_entry                r_tab_rd;
    logic [COUNT_BITS-1:0] r_plc_mem [MAX_TYPES];
    logic [COUNT_BITS-1:0] r_plc_rd;
    logic                  tab_we;
    logic [IDX_W-1:0]      tab_waddr;
    t_entry                tab_wdata;

    logic [MAX_TYPES-1:0] r_ld_valid;
    logic [MAX_TYPES-1:0] r_fits;
    logic [MAX_TYPES-1:0] r_placed;

    logic [15:0]      r_next_server;
    logic [CNT_W-1:0] r_i;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic             r_any, r_big, r_found;
    logic [IDX_W-1:0] r_big_idx;
    logic [COUNT_BITS-1:0] r_big_rem;

    logic [CPU_W-1:0]      r_best_cpu;
    logic [MEM_W-1:0]      r_best_mem;
    logic [COUNT_BITS-1:0] r_best_rem;
    logic [IDX_W-1:0]      r_best_idx;
    logic [CPU_W-1:0]      r_cpu_left;
    logic [MEM_W-1:0]      r_mem_left;

    logic [MEM_W-1:0] r_dvc_q, r_dvc_r, r_dvm_q, r_dvm_r;
    logic [3:0]       r_step;
    logic [COUNT_BITS-1:0] r_k;
    logic [CPU_W-1:0] r_pc;
    logic [MEM_W-1:0] r_pm;
    logic [4:0]       r_emitted;

    logic             r_out_valid;
    t_out             r_out;

    // combinational
    logic [CNT_W-1:0] n_types;
    logic             out_free, in_acc, scan_active, scan_done;
    logic             load_wr;
    logic [COUNT_BITS-1:0] rd_rem;
    logic             oversize, elig, better;
    logic [MEM_W-1:0] a1, a2, b1, b2;
    logic [MEM_W:0]   tc, tm;
    logic [COUNT_BITS-1:0] n_k;
    logic [MAX_TYPES-1:0]  above_mask;
    logic             rep_last;
    logic             emit;
    t_out             emit_data;

    assign o_cfg_ready = 1'b1;
    assign n_types = (32'(r_type_count) > MAX_TYPES) ? CNT_W'(MAX_TYPES) : CNT_W'(r_type_count);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc = i_in_valid && !o_in_stall;
    assign scan_active = (r_state == S_CHK) || (r_state == S_SEL);
    assign scan_done = (r_i == n_types) && !r_pv;
    assign load_wr = in_acc && (t_cmd'(i_in_data.cmd) == CMD_LOAD)
                     && (32'(i_in_data.type_index) < MAX_TYPES);

    // an entry never loaded since reset or clear holds no demand
    assign rd_rem = r_ld_valid[r_pidx] ? r_tab_rd.rem : '0;
    assign oversize = (r_tab_rd.cpu > r_server_cpu) || (r_tab_rd.mem > r_server_mem);
    assign elig = (rd_rem != '0) && r_fits[r_pidx]
                  && (r_tab_rd.cpu <= r_cpu_left) && (r_tab_rd.mem <= r_mem_left);
    assign a1 = r_optimize_mem ? r_tab_rd.mem : MEM_W'(r_tab_rd.cpu);
    assign a2 = r_optimize_mem ? MEM_W'(r_tab_rd.cpu) : r_tab_rd.mem;
    assign b1 = r_optimize_mem ? r_best_mem : MEM_W'(r_best_cpu);
    assign b2 = r_optimize_mem ? MEM_W'(r_best_cpu) : r_best_mem;
    assign better = !r_found || (a1 > b1) || ((a1 == b1) && (a2 > b2));

    // one restoring division step each for the cpu and memory quotients
    assign tc = {r_dvc_r, r_dvc_q[MEM_W-1]};
    assign tm = {r_dvm_r, r_dvm_q[MEM_W-1]};

    always_comb begin
        n_k = r_best_rem;
        if (r_best_cpu != '0 && 32'(r_dvc_q) < 32'(n_k)) begin
            n_k = COUNT_BITS'(r_dvc_q);
        end
        if (r_best_mem != '0 && 32'(r_dvm_q) < 32'(n_k)) begin
            n_k = COUNT_BITS'(r_dvm_q);
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_TYPES; j++) begin
            above_mask[j] = (j > 32'(r_i)) && (j < 32'(n_types));
        end
    end
    assign rep_last = (r_emitted == 5'(MAX_RESULTS - 1)) || ((r_placed & above_mask) == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && t_cmd'(i_in_data.cmd) == CMD_PACK) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (scan_done) begin
                    if (!r_any) begin
                        n_state = S_NONE;
                    end else if (r_big) begin
                        n_state = S_BIG;
                    end else begin
                        n_state = S_SEL;
                    end
                end
            end
            S_NONE, S_BIG: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SEL: begin
                if (scan_done) begin
                    n_state = r_found ? S_DIV : S_REP;
                end
            end
            S_DIV: begin
                if (r_step == 4'(DIV_STEPS - 1)) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: n_state = S_MUL;
            S_MUL: n_state = S_UPD;
            S_UPD: n_state = S_SEL;
            S_REP: begin
                if (r_i == n_types) begin
                    n_state = S_IDLE;
                end else if (r_placed[r_i[IDX_W-1:0]]) begin
                    n_state = S_REP_EMIT;
                end
            end
            S_REP_EMIT: begin
                if (out_free) begin
                    n_state = rep_last ? S_IDLE : S_REP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: result beat and table write
    always_comb begin
        emit = 1'b0;
        emit_data = '0;
        tab_we = 1'b0;
        tab_waddr = r_best_idx;
        tab_wdata = '{cpu: r_best_cpu, mem: r_best_mem, rem: r_best_rem - r_k};
        case (r_state)
            S_IDLE: begin
                if (load_wr) begin
                    tab_we = 1'b1;
                    tab_waddr = IDX_W'(i_in_data.type_index);
                    tab_wdata = '{cpu: i_in_data.type_cpu, mem: i_in_data.type_mem,
                                  rem: COUNT_BITS'(i_in_data.type_demand)};
                end
                if (in_acc && t_cmd'(i_in_data.cmd) == CMD_LOAD) begin
                    emit = 1'b1;
                    emit_data.placed_type = i_in_data.type_index;
                    emit_data.status = ST_ACK;
                    emit_data.last = 1'b1;
                end else if (in_acc && t_cmd'(i_in_data.cmd) == CMD_CLEAR) begin
                    emit = 1'b1;
                    emit_data.status = ST_ACK;
                    emit_data.last = 1'b1;
                end
            end
            S_NONE: begin
                emit = out_free;
                emit_data.server_number = r_next_server;
                emit_data.status = ST_NOTHING;
                emit_data.last = 1'b1;
            end
            S_BIG: begin
                emit = out_free;
                emit_data.server_number = r_next_server;
                emit_data.placed_type = 4'(r_big_idx);
                emit_data.placed_count = sat16(r_big_rem);
                emit_data.status = ST_TOO_BIG;
                emit_data.last = 1'b1;
            end
            S_UPD: tab_we = 1'b1;
            S_REP_EMIT: begin
                emit = out_free;
                emit_data.server_number = r_next_server;
                emit_data.placed_type = 4'(r_i);
                emit_data.placed_count = sat16(r_plc_rd);
                emit_data.status = ST_PLACED;
                emit_data.last = rep_last;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        r_tab_rd <= r_tab_mem[r_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_plc_mem[r_best_idx] <= r_k;
        end
        r_plc_rd <= r_plc_mem[r_i[IDX_W-1:0]];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_server_cpu <= SERVER_CPU_RST;
            r_server_mem <= SERVER_MEM_RST;
            r_optimize_mem <= 1'b0;
            r_type_count <= TYPE_COUNT_RST;
            r_ld_valid <= '0;
            r_fits <= '1;
            r_placed <= '0;
            r_next_server <= '0;
            r_i <= '0;
            r_pv <= 1'b0;
            r_any <= 1'b0;
            r_big <= 1'b0;
            r_found <= 1'b0;
            r_step <= '0;
            r_emitted <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SERVER_CPU:   r_server_cpu <= i_cfg_data[7:0];
                    CFG_SERVER_MEM:   r_server_mem <= i_cfg_data;
                    CFG_OPTIMIZE_MEM: r_optimize_mem <= i_cfg_data[0];
                    CFG_TYPE_COUNT:   r_type_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (load_wr) begin
                r_ld_valid[IDX_W'(i_in_data.type_index)] <= 1'b1;
            end
            if (in_acc && t_cmd'(i_in_data.cmd) == CMD_CLEAR) begin
                r_ld_valid <= '0;
                r_next_server <= '0;
            end
            if (in_acc && t_cmd'(i_in_data.cmd) == CMD_PACK) begin
                r_i <= '0;
                r_pv <= 1'b0;
                r_any <= 1'b0;
                r_big <= 1'b0;
            end

            // pipelined table scan: address now, data next cycle
            if (scan_active) begin
                r_pv <= (r_i < n_types);
                if (r_i < n_types) begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (r_state == S_CHK && r_pv && rd_rem != '0) begin
                r_any <= 1'b1;
                if (oversize) begin
                    r_big <= 1'b1;
                end
            end
            if (r_state == S_SEL && r_pv && elig && better) begin
                r_found <= 1'b1;
            end

            // fresh server
            if (r_state == S_CHK && n_state == S_SEL) begin
                r_fits <= '1;
                r_placed <= '0;
            end
            if (n_state == S_SEL && r_state != S_SEL) begin
                r_i <= '0;
                r_pv <= 1'b0;
                r_found <= 1'b0;
            end
            if (r_state == S_SEL && n_state == S_DIV) begin
                r_step <= '0;
            end
            if (r_state == S_DIV) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == S_UPD) begin
                r_fits[r_best_idx] <= 1'b0;
                r_placed[r_best_idx] <= 1'b1;
            end

            if (r_state == S_SEL && n_state == S_REP) begin
                r_i <= '0;
                r_emitted <= '0;
            end
            if (r_state == S_REP && n_state == S_IDLE) begin
                r_next_server <= r_next_server + 1'b1;
            end
            if (r_state == S_REP && r_i != n_types && !r_placed[r_i[IDX_W-1:0]]) begin
                r_i <= r_i + 1'b1;
            end
            if (r_state == S_REP_EMIT && out_free) begin
                if (rep_last) begin
                    r_next_server <= r_next_server + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                    r_emitted <= r_emitted + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_data;
        end
        r_pidx <= r_i[IDX_W-1:0];

        if (r_state == S_CHK && r_pv && rd_rem != '0 && oversize && !r_big) begin
            r_big_idx <= r_pidx;
            r_big_rem <= rd_rem;
        end
        if (r_state == S_CHK && n_state == S_SEL) begin
            r_cpu_left <= r_server_cpu;
            r_mem_left <= r_server_mem;
        end
        if (r_state == S_SEL && r_pv && elig && better) begin
            r_best_cpu <= r_tab_rd.cpu;
            r_best_mem <= r_tab_rd.mem;
            r_best_rem <= rd_rem;
            r_best_idx <= r_pidx;
        end

        if (r_state == S_SEL && n_state == S_DIV) begin
            r_dvc_q <= MEM_W'(r_cpu_left);
            r_dvc_r <= '0;
            r_dvm_q <= r_mem_left;
            r_dvm_r <= '0;
        end
        if (r_state == S_DIV) begin
            if (tc >= {1'b0, MEM_W'(r_best_cpu)}) begin
                r_dvc_r <= MEM_W'(tc - {1'b0, MEM_W'(r_best_cpu)});
                r_dvc_q <= {r_dvc_q[MEM_W-2:0], 1'b1};
            end else begin
                r_dvc_r <= MEM_W'(tc);
                r_dvc_q <= {r_dvc_q[MEM_W-2:0], 1'b0};
            end
            if (tm >= {1'b0, r_best_mem}) begin
                r_dvm_r <= MEM_W'(tm - {1'b0, r_best_mem});
                r_dvm_q <= {r_dvm_q[MEM_W-2:0], 1'b1};
            end else begin
                r_dvm_r <= MEM_W'(tm);
                r_dvm_q <= {r_dvm_q[MEM_W-2:0], 1'b0};
            end
        end
        if (r_state == S_MIN) begin
            r_k <= n_k;
        end
        // a nonzero need bounds k by its quotient, so ten bits of k suffice
        if (r_state == S_MUL) begin
            r_pc <= CPU_W'(MEM_W'(r_k) * r_best_cpu);
            r_pm <= MEM_W'(MEM_W'(r_k) * r_best_mem);
        end
        if (r_state == S_UPD) begin
            r_cpu_left <= r_cpu_left - r_pc;
            r_mem_left <= r_mem_left - r_pm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    a_cpu_never_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |=> r_cpu_left <= $past(r_cpu_left))
        else $error("cpu left grew on write-back");

    a_best_has_demand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MIN |-> r_best_rem != '0 && n_k != '0)
        else $error("selected type places nothing");

    a_report_placed_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REP_EMIT |-> r_placed[r_i[IDX_W-1:0]])
        else $error("report beat for a type not placed");

    a_results_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted < 5'(MAX_RESULTS))
        else $error("too many placement beats");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for greedy_two_resource_server_packing.
// Predicts each command's result beats in a behavioural packer and checks the output
// channel against them; depends on gtrsp_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import gtrsp_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in        in_data;
    logic       out_valid;
    logic       out_stall;
    t_out       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;

    greedy_two_resource_server_packing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Packer state as the block should hold it.
    logic [7:0]  srv_cpu;
    logic [9:0]  srv_mem;
    logic        rank_mem;
    logic [4:0]  types_used;
    logic [7:0]  type_cpu_tab [16];
    logic [9:0]  type_mem_tab [16];
    logic [15:0] demand_left [16];
    logic [15:0] server_next;

    t_out pending_results[$];
    int   mismatches;
    bit   send_gaps;
    bit   recv_gaps;
    int   recv_hold;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic expect_beat(input logic [15:0] srv, input logic [3:0] typ,
                               input logic [15:0] cnt, input t_status st, input logic lst);
        t_out r;
        r.server_number = srv;
        r.placed_type   = typ;
        r.placed_count  = cnt;
        r.status        = st;
        r.last          = lst;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic clear_packer();
        for (int i = 0; i < 16; i++) begin
            type_cpu_tab[i] = '0;
            type_mem_tab[i] = '0;
            demand_left[i]  = '0;
        end
        server_next = '0;
    endtask

    task automatic pack_server();
        int          n;
        int          big;
        int          best;
        int          last_i;
        bit          any;
        bit          retired [16];
        int unsigned placed [16];
        int unsigned cpu_free;
        int unsigned mem_free;
        int unsigned k;
        int unsigned a1, a2, b1, b2;
        n = (types_used > 16) ? 16 : types_used;
        any = 1'b0;
        big = -1;
        for (int i = 0; i < n; i++) begin
            if (demand_left[i] != 0) begin
                any = 1'b1;
                if (big < 0 && (type_cpu_tab[i] > srv_cpu || type_mem_tab[i] > srv_mem))
                    big = i;
            end
        end
        if (!any) begin
            expect_beat(server_next, '0, '0, ST_NOTHING, 1'b1);
            return;
        end
        if (big >= 0) begin
            expect_beat(server_next, big[3:0], demand_left[big], ST_TOO_BIG, 1'b1);
            return;
        end
        cpu_free = srv_cpu;
        mem_free = srv_mem;
        for (int i = 0; i < 16; i++) begin
            retired[i] = 1'b0;
            placed[i]  = 0;
        end
        forever begin
            best = -1;
            for (int i = 0; i < n; i++) begin
                if (demand_left[i] == 0 || retired[i] || type_cpu_tab[i] > cpu_free ||
                    type_mem_tab[i] > mem_free)
                    continue;
                if (best < 0) begin
                    best = i;
                    continue;
                end
                a1 = rank_mem ? type_mem_tab[i] : type_cpu_tab[i];
                a2 = rank_mem ? type_cpu_tab[i] : type_mem_tab[i];
                b1 = rank_mem ? type_mem_tab[best] : type_cpu_tab[best];
                b2 = rank_mem ? type_cpu_tab[best] : type_mem_tab[best];
                if (a1 > b1 || (a1 == b1 && a2 > b2))
                    best = i;
            end
            if (best < 0)
                break;
            k = demand_left[best];
            if (type_cpu_tab[best] != 0 && cpu_free / type_cpu_tab[best] < k)
                k = cpu_free / type_cpu_tab[best];
            if (type_mem_tab[best] != 0 && mem_free / type_mem_tab[best] < k)
                k = mem_free / type_mem_tab[best];
            demand_left[best] = demand_left[best] - k[15:0];
            placed[best] += k;
            cpu_free -= k * type_cpu_tab[best];
            mem_free -= k * type_mem_tab[best];
            retired[best] = 1'b1;
        end
        last_i = -1;
        for (int i = 0; i < n; i++)
            if (placed[i] != 0)
                last_i = i;
        for (int i = 0; i < n; i++)
            if (placed[i] != 0)
                expect_beat(server_next, i[3:0], placed[i][15:0], ST_PLACED, i == last_i);
        server_next = server_next + 16'd1;
    endtask

    task automatic predict_command(input t_in it);
        case (it.cmd)
            CMD_LOAD: begin
                type_cpu_tab[it.type_index] = it.type_cpu;
                type_mem_tab[it.type_index] = it.type_mem;
                demand_left[it.type_index]  = it.type_demand;
                expect_beat('0, it.type_index, '0, ST_ACK, 1'b1);
            end
            CMD_PACK: pack_server();
            CMD_CLEAR: begin
                clear_packer();
                expect_beat('0, '0, '0, ST_ACK, 1'b1);
            end
            default: ;
        endcase
    endtask

    // Called at a rising edge; leaves valid high so back-to-back beats need no toggle.
    task automatic send_cmd(input t_in it);
        if (send_gaps && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        predict_command(it);
    endtask

    task automatic send_load(input int idx, input int c, input int m, input int d);
        t_in it;
        it.cmd = CMD_LOAD;
        it.type_index = idx[3:0];
        it.type_cpu = c[7:0];
        it.type_mem = m[9:0];
        it.type_demand = d[15:0];
        send_cmd(it);
    endtask

    task automatic send_op(input logic [1:0] op);
        t_in it;
        it.cmd = op;
        it.type_index = 4'($urandom);
        it.type_cpu = 8'($urandom);
        it.type_mem = 10'($urandom);
        it.type_demand = 16'($urandom);
        send_cmd(it);
    endtask

    // Hold input low and wait for every expected beat, plus slack for trailing work.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_config(input int c, input int m, input int opt, input int cnt);
        t_cfg_idx idx [4];
        int       val [4];
        idx = '{CFG_SERVER_CPU, CFG_SERVER_MEM, CFG_OPTIMIZE_MEM, CFG_TYPE_COUNT};
        val = '{c, m, opt, cnt};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i][9:0];
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        srv_cpu    = c[7:0];
        srv_mem    = m[9:0];
        rank_mem   = opt[0];
        types_used = cnt[4:0];
    endtask

    task automatic load_random_type(input int idx);
        int c, m, d;
        if ($urandom_range(9) == 0) begin
            c = $urandom_range(255);
            m = $urandom_range(1023);
            d = $urandom_range(65535);
        end else begin
            c = $urandom_range(srv_cpu / 3);
            m = $urandom_range(srv_mem / 3);
            d = $urandom_range(40);
        end
        send_load(idx, c, m, d);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (out_data.server_number !== want.server_number)
                    report_mismatch($sformatf("server_number %0d want %0d",
                        out_data.server_number, want.server_number));
                if (out_data.placed_type !== want.placed_type)
                    report_mismatch($sformatf("placed_type %0d want %0d",
                        out_data.placed_type, want.placed_type));
                if (out_data.placed_count !== want.placed_count)
                    report_mismatch($sformatf("placed_count %0d want %0d",
                        out_data.placed_count, want.placed_count));
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d",
                        out_data.status, want.status));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b", out_data.last, want.last));
            end
        end
    end

    // Receiver stall generator; count down a long hold here.
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= recv_gaps && ($urandom_range(99) < 15);
        end
    end

    task automatic test_defaults();
        for (int i = 0; i < 16; i++)
            send_load(i, $urandom_range(1, 12), $urandom_range(1, 30), $urandom_range(0, 6));
        repeat (3) send_op(CMD_PACK);
        drain();
    endtask

    task automatic test_directed();
        send_load(15, 255, 1023, 65535);
        send_op(CMD_PACK);          // oversized type reported, nothing packed
        send_op(CMD_CLEAR);
        send_op(CMD_PACK);          // empty table: nothing to do
        send_load(0, 0, 0, 65535);  // zero-size type: whole demand on one server
        send_load(1, 56, 128, 2);   // exactly one empty server
        send_op(CMD_PACK);
        send_op(CMD_PACK);
        send_op(2'd3);              // unused command, no beat
        drain();
        set_config(255, 1023, 1, 31);   // type count above the table size saturates
        send_load(15, 255, 1023, 65535);
        send_load(3, 17, 900, 5);
        send_load(4, 17, 950, 5);
        send_op(CMD_PACK);
        send_op(CMD_PACK);
        drain();
        set_config(1, 1, 0, 0);     // no types in use
        send_op(CMD_PACK);
        drain();
    endtask

    task automatic test_random();
        int r;
        for (int ph = 0; ph < 6; ph++) begin
            send_gaps = (ph != 2);
            recv_gaps = (ph != 2);
            case (ph)
                0: set_config(255, 1023, 0, 16);
                1: set_config(1, 1, 1, 1);
                default: set_config($urandom_range(1, 255), $urandom_range(1, 1023),
                                    $urandom_range(1), $urandom_range(1, 16));
            endcase
            for (int i = 0; i < 10; i++) begin
                r = $urandom_range(99);
                if (r < 55)
                    send_op(CMD_PACK);
                else if (r < 92)
                    load_random_type($urandom_range(15));
                else if (r < 96)
                    send_op(CMD_CLEAR);
                else
                    send_op(2'd3);
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        set_config(60, 200, 0, 8);
        for (int i = 0; i < 8; i++)
            send_load(i, $urandom_range(1, 10), $urandom_range(1, 30), $urandom_range(5, 30));
        recv_hold = 400;
        repeat (6) send_op(CMD_PACK);
        drain();
        // sender waits for every beat before each command
        repeat (3) begin
            send_op(CMD_PACK);
            drain();
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SERVER_CPU;
        cfg_data  <= '0;
        mismatches = 0;
        send_gaps  = 1'b1;
        recv_gaps  = 1'b1;
        recv_hold  = 0;
        srv_cpu    = SERVER_CPU_RST;
        srv_mem    = SERVER_MEM_RST;
        rank_mem   = 1'b0;
        types_used = TYPE_COUNT_RST;
        clear_packer();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_directed();
        test_random();
        test_backpressure();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
